// ===== src/dcmr_pkg.sv =====
`default_nettype none

package dcmr_pkg;

    // Width of one matrix element on the ports (signed, Q2.16 by default).
    localparam int ELEM_W = 18;

    // Default number of fraction bits in an element.
    localparam int FRAC_BITS_DEF = 16;

    // Register stages between the input and the output ports.
    localparam int NUM_STAGES = 14;

    // Width into which every value is sign-extended before saturation.
    localparam int SAT_W = 64;

    typedef logic signed [ELEM_W-1:0] elem_t;

endpackage

`default_nettype wire

// ===== src/dcm_renormalize_core.sv =====
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    in_xx .. in_zz, nine signed elements
// out      out_valid / out_ready  out_xx .. out_zz, nine signed elements
//
// A matrix passes through every register stage of the pipeline, and a new
// matrix may enter in every cycle while in_ready is high. Each stage holds at
// most one multiplier level or one adder tree with rounding and saturation.
// Reset clears only the valid bit of each stage; the data registers need none.
// A stage advances when it is empty or when the stage after it advances, so
// bubbles close up while the output is stalled and in_ready falls only when
// every stage holds a matrix.

module dcm_renormalize_core #(
    parameter int FRAC_BITS = dcmr_pkg::FRAC_BITS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,

    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire dcmr_pkg::elem_t in_xx,
    input  wire dcmr_pkg::elem_t in_xy,
    input  wire dcmr_pkg::elem_t in_xz,
    input  wire dcmr_pkg::elem_t in_yx,
    input  wire dcmr_pkg::elem_t in_yy,
    input  wire dcmr_pkg::elem_t in_yz,
    input  wire dcmr_pkg::elem_t in_zx,
    input  wire dcmr_pkg::elem_t in_zy,
    input  wire dcmr_pkg::elem_t in_zz,

    output logic                out_valid,
    input  wire logic           out_ready,
    output dcmr_pkg::elem_t     out_xx,
    output dcmr_pkg::elem_t     out_xy,
    output dcmr_pkg::elem_t     out_xz,
    output dcmr_pkg::elem_t     out_yx,
    output dcmr_pkg::elem_t     out_yy,
    output dcmr_pkg::elem_t     out_yz,
    output dcmr_pkg::elem_t     out_zx,
    output dcmr_pkg::elem_t     out_zy,
    output dcmr_pkg::elem_t     out_zz
);

    localparam int E    = dcmr_pkg::ELEM_W;
    localparam int F    = FRAC_BITS;
    localparam int NS   = dcmr_pkg::NUM_STAGES;
    localparam int SATW = dcmr_pkg::SAT_W;

    // Exact product of two elements, and a sum of three such products.
    localparam int PW  = 2 * E;
    localparam int SW3 = PW + 2;
    // Half error and its products with the elements of a row. The product is
    // kept at least two bits above the fraction so that its rounded integer part
    // always exists, even with many fraction bits.
    localparam int HW  = SW3 - F - 1;
    localparam int HPW = ((HW + E) > (F + 2)) ? (HW + E) : (F + 2);
    // Scale factor (3 - |r|^2)/2 and its products with the elements of a row.
    localparam int KIN = ((2 * F + 3) > SW3 ? (2 * F + 3) : SW3) + 1;
    localparam int KW  = KIN - F - 1;
    localparam int KPW = KW + E;
    // Difference in the subtraction of the correction term; wide enough for
    // both the element and the rounded correction.
    localparam int DW  = (((HPW - F) > E) ? (HPW - F) : E) + 1;

    localparam logic signed [SW3-1:0] HALF_E = SW3'(1) <<< F;
    localparam logic signed [HPW-1:0] HALF_H = HPW'(1) <<< (F - 1);
    localparam logic signed [KIN-1:0] HALF_K = KIN'(1) <<< F;
    localparam logic signed [KIN-1:0] THREE  = KIN'(3) <<< (2 * F);
    localparam logic signed [KPW-1:0] HALF_P = KPW'(1) <<< (F - 1);
    localparam logic signed [PW:0]    HALF_C = (PW + 1)'(1) <<< (F - 1);

    localparam logic signed [SATW-1:0] SAT_MAX = SATW'((64'sd1 <<< (E - 1)) - 64'sd1);
    localparam logic signed [SATW-1:0] SAT_MIN = -SAT_MAX - SATW'(1);

    // Clamp a sign-extended value to the element range.
    function automatic dcmr_pkg::elem_t sat(input logic signed [SATW-1:0] v);
        dcmr_pkg::elem_t r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[E-1:0];
        end
        else if (v < SAT_MIN) begin
            r = SAT_MIN[E-1:0];
        end
        else begin
            r = v[E-1:0];
        end
        return r;
    endfunction

    // Scale factor round((3 - (a + b + c)) / 2) from three squares.
    function automatic logic signed [KW-1:0] scale_of(
        input logic signed [PW-1:0] a,
        input logic signed [PW-1:0] b,
        input logic signed [PW-1:0] c
    );
        logic signed [SW3-1:0] n;
        logic signed [KIN-1:0] d;
        n = SW3'(a) + SW3'(b) + SW3'(c);
        d = THREE - KIN'(n) + HALF_K;
        return $signed(d[KIN-1:F+1]);
    endfunction

    // Round a product of an element and a scale factor back to an element.
    function automatic dcmr_pkg::elem_t round_scaled(input logic signed [KPW-1:0] p);
        logic signed [KPW-1:0] t;
        t = p + HALF_P;
        return sat(SATW'($signed(t[KPW-1:F])));
    endfunction

    // ------------------------------------------------------------------
    // Flow control: one valid bit per stage, bubbles are squeezed out.
    // ------------------------------------------------------------------
    logic [NS:1] valid_reg;
    logic [NS:1] stage_en;

    always_comb
    begin
        stage_en[NS] = ~valid_reg[NS] | out_ready;
        for (int s = NS - 1; s >= 1; s--)
        begin
            stage_en[s] = ~valid_reg[s] | stage_en[s+1];
        end
    end

    assign in_ready  = stage_en[1];
    assign out_valid = valid_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int s = 2; s <= NS; s++)
            begin
                if (stage_en[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Data path. Row Z of the input is not used: it is rebuilt from X and Y.
    // ------------------------------------------------------------------
    dcmr_pkg::elem_t in_x [3];
    dcmr_pkg::elem_t in_y [3];

    assign in_x[0] = in_xx;
    assign in_x[1] = in_xy;
    assign in_x[2] = in_xz;
    assign in_y[0] = in_yx;
    assign in_y[1] = in_yy;
    assign in_y[2] = in_yz;

    // Original rows, carried through the correction stages.
    dcmr_pkg::elem_t x_reg [1:3][3];
    dcmr_pkg::elem_t y_reg [1:3][3];
    // Corrected rows, carried through their own renormalization.
    dcmr_pkg::elem_t nx_reg [4:6][3];
    dcmr_pkg::elem_t ny_reg [4:6][3];
    // Final rows X and Y, carried while Z is built and scaled.
    dcmr_pkg::elem_t rx_reg [8:NS][3];
    dcmr_pkg::elem_t ry_reg [8:NS][3];
    // Raw cross product, carried through its renormalization.
    dcmr_pkg::elem_t z_reg [10:12][3];

    logic signed [PW-1:0]  pxy_reg [3];
    logic signed [HW-1:0]  h_reg;
    logic signed [HPW-1:0] hy_reg [3];
    logic signed [HPW-1:0] hx_reg [3];
    logic signed [PW-1:0]  sqx_reg [3];
    logic signed [PW-1:0]  sqy_reg [3];
    logic signed [KW-1:0]  kx_reg;
    logic signed [KW-1:0]  ky_reg;
    logic signed [KPW-1:0] pkx_reg [3];
    logic signed [KPW-1:0] pky_reg [3];
    logic signed [PW-1:0]  cpa_reg [3];
    logic signed [PW-1:0]  cpb_reg [3];
    logic signed [PW-1:0]  sqz_reg [3];
    logic signed [KW-1:0]  kz_reg;
    logic signed [KPW-1:0] pkz_reg [3];
    dcmr_pkg::elem_t       zf_reg [3];

    logic signed [PW-1:0]  pxy_next [3];
    logic signed [HW-1:0]  h_next;
    logic signed [HPW-1:0] hy_next [3];
    logic signed [HPW-1:0] hx_next [3];
    dcmr_pkg::elem_t       nx_next [3];
    dcmr_pkg::elem_t       ny_next [3];
    dcmr_pkg::elem_t       rx_next [3];
    dcmr_pkg::elem_t       ry_next [3];
    logic signed [PW-1:0]  cpa_next [3];
    logic signed [PW-1:0]  cpb_next [3];
    dcmr_pkg::elem_t       z_next [3];
    dcmr_pkg::elem_t       zf_next [3];

    logic signed [SW3-1:0] e_sum;
    logic signed [HPW-1:0] hy_rnd [3];
    logic signed [HPW-1:0] hx_rnd [3];
    logic signed [DW-1:0]  dx [3];
    logic signed [DW-1:0]  dy [3];
    logic signed [PW:0]    cp_diff [3];

    always_comb
    begin
        // Stage 1: products of the dot product X.Y.
        for (int i = 0; i < 3; i++)
        begin
            pxy_next[i] = in_x[i] * in_y[i];
        end

        // Stage 2: half error h = round(e / 2).
        e_sum  = SW3'(pxy_reg[0]) + SW3'(pxy_reg[1]) + SW3'(pxy_reg[2]) + HALF_E;
        h_next = $signed(e_sum[SW3-1:F+1]);

        // Stage 3: correction products, both from the original rows.
        for (int i = 0; i < 3; i++)
        begin
            hy_next[i] = h_reg * y_reg[2][i];
            hx_next[i] = h_reg * x_reg[2][i];
        end

        // Stage 4: subtract the rounded correction and saturate.
        for (int i = 0; i < 3; i++)
        begin
            hy_rnd[i]  = hy_reg[i] + HALF_H;
            hx_rnd[i]  = hx_reg[i] + HALF_H;
            dx[i]      = DW'(x_reg[3][i]) - DW'($signed(hy_rnd[i][HPW-1:F]));
            dy[i]      = DW'(y_reg[3][i]) - DW'($signed(hx_rnd[i][HPW-1:F]));
            nx_next[i] = sat(SATW'(dx[i]));
            ny_next[i] = sat(SATW'(dy[i]));
        end

        // Stage 8: round the scaled rows X and Y.
        for (int i = 0; i < 3; i++)
        begin
            rx_next[i] = round_scaled(pkx_reg[i]);
            ry_next[i] = round_scaled(pky_reg[i]);
        end

        // Stage 9: the six products of the cross product X x Y.
        cpa_next[0] = rx_reg[8][1] * ry_reg[8][2];
        cpb_next[0] = rx_reg[8][2] * ry_reg[8][1];
        cpa_next[1] = rx_reg[8][2] * ry_reg[8][0];
        cpb_next[1] = rx_reg[8][0] * ry_reg[8][2];
        cpa_next[2] = rx_reg[8][0] * ry_reg[8][1];
        cpb_next[2] = rx_reg[8][1] * ry_reg[8][0];

        // Stage 10: differences, rounded and saturated to elements.
        for (int i = 0; i < 3; i++)
        begin
            cp_diff[i] = (PW + 1)'(cpa_reg[i]) - (PW + 1)'(cpb_reg[i]) + HALF_C;
            z_next[i]  = sat(SATW'($signed(cp_diff[i][PW:F])));
        end

        // Stage 14: round the scaled row Z.
        for (int i = 0; i < 3; i++)
        begin
            zf_next[i] = round_scaled(pkz_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            x_reg[1]    <= in_x;
            y_reg[1]    <= in_y;
            pxy_reg     <= pxy_next;
        end
        if (stage_en[2])
        begin
            x_reg[2]    <= x_reg[1];
            y_reg[2]    <= y_reg[1];
            h_reg       <= h_next;
        end
        if (stage_en[3])
        begin
            x_reg[3]    <= x_reg[2];
            y_reg[3]    <= y_reg[2];
            hy_reg      <= hy_next;
            hx_reg      <= hx_next;
        end
        if (stage_en[4])
        begin
            nx_reg[4]   <= nx_next;
            ny_reg[4]   <= ny_next;
        end
        if (stage_en[5])
        begin
            nx_reg[5]   <= nx_reg[4];
            ny_reg[5]   <= ny_reg[4];
            for (int i = 0; i < 3; i++)
            begin
                sqx_reg[i] <= nx_reg[4][i] * nx_reg[4][i];
                sqy_reg[i] <= ny_reg[4][i] * ny_reg[4][i];
            end
        end
        if (stage_en[6])
        begin
            nx_reg[6]   <= nx_reg[5];
            ny_reg[6]   <= ny_reg[5];
            kx_reg      <= scale_of(sqx_reg[0], sqx_reg[1], sqx_reg[2]);
            ky_reg      <= scale_of(sqy_reg[0], sqy_reg[1], sqy_reg[2]);
        end
        if (stage_en[7])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pkx_reg[i] <= nx_reg[6][i] * kx_reg;
                pky_reg[i] <= ny_reg[6][i] * ky_reg;
            end
        end
        if (stage_en[8])
        begin
            rx_reg[8]   <= rx_next;
            ry_reg[8]   <= ry_next;
        end
        for (int s = 9; s <= NS; s++)
        begin
            if (stage_en[s])
            begin
                rx_reg[s] <= rx_reg[s-1];
                ry_reg[s] <= ry_reg[s-1];
            end
        end
        if (stage_en[9])
        begin
            cpa_reg     <= cpa_next;
            cpb_reg     <= cpb_next;
        end
        if (stage_en[10])
        begin
            z_reg[10]   <= z_next;
        end
        if (stage_en[11])
        begin
            z_reg[11]   <= z_reg[10];
            for (int i = 0; i < 3; i++)
            begin
                sqz_reg[i] <= z_reg[10][i] * z_reg[10][i];
            end
        end
        if (stage_en[12])
        begin
            z_reg[12]   <= z_reg[11];
            kz_reg      <= scale_of(sqz_reg[0], sqz_reg[1], sqz_reg[2]);
        end
        if (stage_en[13])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pkz_reg[i] <= z_reg[12][i] * kz_reg;
            end
        end
        if (stage_en[14])
        begin
            zf_reg      <= zf_next;
        end
    end

    assign out_xx = rx_reg[NS][0];
    assign out_xy = rx_reg[NS][1];
    assign out_xz = rx_reg[NS][2];
    assign out_yx = ry_reg[NS][0];
    assign out_yy = ry_reg[NS][1];
    assign out_yz = ry_reg[NS][2];
    assign out_zx = zf_reg[0];
    assign out_zy = zf_reg[1];
    assign out_zz = zf_reg[2];

`ifndef SYNTHESIS
    // A consumer that is ready lets every stage move, so the input is ready too.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low although out_ready is high");

    // The input is refused only when the whole pipeline is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg))
        else $error("input refused while a stage is empty");

    // An accepted matrix occupies the first stage in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[1])
        else $error("accepted matrix lost at the first stage");
`endif

endmodule

`default_nettype wire
